// File: design/stpd_pkg.sv
// shared types, constants and the poll table of the servo telemetry poll decoder
package stpd_pkg;

	localparam int REPLY_TIMER_BITS = 16;
	localparam int RT_CMP_W = (REPLY_TIMER_BITS > 16) ? REPLY_TIMER_BITS : 16;

	localparam int POLL_SLOTS = 14;
	localparam int SLOT_W = $clog2(POLL_SLOTS);

	// input modes
	localparam logic [1:0] MODE_FRAME = 2'd0;
	localparam logic [1:0] MODE_TICK  = 2'd1;
	localparam logic [1:0] MODE_READ  = 2'd2;

	// result kinds
	localparam logic KIND_SEND = 1'b0;
	localparam logic KIND_READ = 1'b1;

	// command bytes
	localparam logic [7:0] CMD_POSITION = 8'h31;
	localparam logic [7:0] CMD_SPEED    = 8'h32;
	localparam logic [7:0] CMD_ERRORS   = 8'h39;
	localparam logic [7:0] CMD_RUN_STAT = 8'hF1;
	localparam logic [7:0] CMD_ENABLED  = 8'h3A;
	localparam logic [7:0] CMD_STALLED  = 8'h3E;
	localparam logic [7:0] CMD_ALARM    = 8'h37;
	localparam logic [7:0] CMD_HOMED    = 8'h3B;
	localparam logic [7:0] CMD_DRV_MODE = 8'h82;
	localparam logic [7:0] CMD_VERSION  = 8'h40;
	localparam logic [7:0] CMD_PARAM_RD = 8'h00;
	localparam logic [7:0] ARG_DRV_MODE = 8'h82;

	// exact reply lengths
	localparam logic [3:0] LEN_POSITION = 4'd8;
	localparam logic [3:0] LEN_SPEED    = 4'd4;
	localparam logic [3:0] LEN_ERRORS   = 4'd6;
	localparam logic [3:0] LEN_VERSION  = 4'd6;
	localparam logic [3:0] LEN_SHORT    = 4'd3;

	// telemetry read indexes
	localparam logic [3:0] RD_POSITION  = 4'd0;
	localparam logic [3:0] RD_SPEED     = 4'd1;
	localparam logic [3:0] RD_ERRORS    = 4'd2;
	localparam logic [3:0] RD_RUN_STAT  = 4'd3;
	localparam logic [3:0] RD_ENABLED   = 4'd4;
	localparam logic [3:0] RD_STALLED   = 4'd5;
	localparam logic [3:0] RD_ALARM     = 4'd6;
	localparam logic [3:0] RD_HOMED     = 4'd7;
	localparam logic [3:0] RD_DRV_MODE  = 4'd8;
	localparam logic [3:0] RD_HW_REV    = 4'd9;
	localparam logic [3:0] RD_FW_REV    = 4'd10;
	localparam logic [3:0] RD_VER_KNOWN = 4'd11;
	localparam logic [3:0] RD_FRAMES    = 4'd12;
	localparam logic [3:0] RD_ONLINE    = 4'd13;

	// configuration register indexes
	localparam logic [1:0] REG_SERVO_ID  = 2'd0;
	localparam logic [1:0] REG_POLL_STEP = 2'd1;
	localparam logic [1:0] REG_SLOW_POLL = 2'd2;
	localparam logic [1:0] REG_TIMEOUT   = 2'd3;

	localparam logic [10:0] SERVO_ID_RST  = 11'd1;
	localparam logic [7:0]  POLL_STEP_RST = 8'd10;
	localparam logic [15:0] SLOW_POLL_RST = 16'd2000;
	localparam logic [15:0] TIMEOUT_RST   = 16'd500;

	typedef struct packed {
		logic [1:0]  mode;
		logic [10:0] frame_id;
		logic [3:0]  frame_len;
		logic [63:0] frame_data;
		logic [3:0]  read_index;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  send_command;
		logic        send_has_arg;
		logic [7:0]  send_arg;
		logic [63:0] read_value;
		logic        online;
		logic        last;
	} out_item_t;

	// accepted reply frame handed to the telemetry registers
	typedef struct packed {
		logic        hit;
		logic [3:0]  len;
		logic [63:0] data;
	} frame_upd_t;

	// link status kept at the top level but readable as telemetry
	typedef struct packed {
		logic [31:0] frame_count;
		logic        online;
	} link_stat_t;

	function automatic logic [7:0] poll_cmd(input logic [SLOT_W-1:0] slot);
		logic [7:0] cmd;
		case (slot)
			4'd0, 4'd2, 4'd4, 4'd6, 4'd8, 4'd10, 4'd12: cmd = CMD_POSITION;
			4'd1:  cmd = CMD_SPEED;
			4'd3:  cmd = CMD_ERRORS;
			4'd5:  cmd = CMD_RUN_STAT;
			4'd7:  cmd = CMD_ENABLED;
			4'd9:  cmd = CMD_STALLED;
			4'd11: cmd = CMD_ALARM;
			4'd13: cmd = CMD_HOMED;
			default: cmd = CMD_POSITION;
		endcase
		return cmd;
	endfunction

endpackage

// File: design/stpd_telem_regs.sv
// decoded telemetry registers, reply frame decode and telemetry read select
module stpd_telem_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  stpd_pkg::frame_upd_t upd,
	input  stpd_pkg::link_stat_t stat,
	input  logic [3:0]          read_index,
	output logic [63:0]         read_value
);

	logic [47:0] position_q;
	logic [15:0] speed_q;
	logic [31:0] error_count_q;
	logic [7:0]  run_status_q;
	logic        enabled_q;
	logic        stalled_q;
	logic [7:0]  alarm_q;
	logic        homed_q;
	logic [7:0]  drive_mode_q;
	logic [3:0]  hw_rev_q;
	logic [23:0] fw_rev_q;
	logic        ver_known_q;

	logic [7:0] cmd;
	logic [7:0] b1;
	logic       b1_one;

	assign cmd    = upd.data[63:56];
	assign b1     = upd.data[55:48];
	assign b1_one = (b1 == 8'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q    <= '0;
			speed_q       <= '0;
			error_count_q <= '0;
			run_status_q  <= '0;
			enabled_q     <= 1'b0;
			stalled_q     <= 1'b0;
			alarm_q       <= '0;
			homed_q       <= 1'b0;
			drive_mode_q  <= '0;
			hw_rev_q      <= '0;
			fw_rev_q      <= '0;
			ver_known_q   <= 1'b0;
		end else if (upd.hit) begin
			case (cmd)
				stpd_pkg::CMD_POSITION: begin
					if (upd.len == stpd_pkg::LEN_POSITION) position_q <= upd.data[55:8];
				end
				stpd_pkg::CMD_SPEED: begin
					if (upd.len == stpd_pkg::LEN_SPEED) speed_q <= upd.data[55:40];
				end
				stpd_pkg::CMD_ERRORS: begin
					if (upd.len == stpd_pkg::LEN_ERRORS) error_count_q <= upd.data[55:24];
				end
				stpd_pkg::CMD_RUN_STAT: begin
					if (upd.len == stpd_pkg::LEN_SHORT) run_status_q <= b1;
				end
				stpd_pkg::CMD_ENABLED: begin
					if (upd.len == stpd_pkg::LEN_SHORT) enabled_q <= b1_one;
				end
				stpd_pkg::CMD_STALLED: begin
					if (upd.len == stpd_pkg::LEN_SHORT) stalled_q <= b1_one;
				end
				stpd_pkg::CMD_ALARM: begin
					if (upd.len == stpd_pkg::LEN_SHORT) alarm_q <= b1;
				end
				stpd_pkg::CMD_HOMED: begin
					if (upd.len == stpd_pkg::LEN_SHORT) homed_q <= b1_one;
				end
				stpd_pkg::CMD_DRV_MODE: begin
					if (upd.len == stpd_pkg::LEN_SHORT) drive_mode_q <= b1;
				end
				stpd_pkg::CMD_VERSION: begin
					if (upd.len == stpd_pkg::LEN_VERSION) begin
						hw_rev_q    <= b1[3:0];
						fw_rev_q    <= upd.data[47:24];
						ver_known_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// signed items are sign-extended
	always_comb begin
		case (read_index)
			stpd_pkg::RD_POSITION:  read_value = {{16{position_q[47]}}, position_q};
			stpd_pkg::RD_SPEED:     read_value = {{48{speed_q[15]}}, speed_q};
			stpd_pkg::RD_ERRORS:    read_value = {{32{error_count_q[31]}}, error_count_q};
			stpd_pkg::RD_RUN_STAT:  read_value = {56'd0, run_status_q};
			stpd_pkg::RD_ENABLED:   read_value = {63'd0, enabled_q};
			stpd_pkg::RD_STALLED:   read_value = {63'd0, stalled_q};
			stpd_pkg::RD_ALARM:     read_value = {56'd0, alarm_q};
			stpd_pkg::RD_HOMED:     read_value = {63'd0, homed_q};
			stpd_pkg::RD_DRV_MODE:  read_value = {56'd0, drive_mode_q};
			stpd_pkg::RD_HW_REV:    read_value = {60'd0, hw_rev_q};
			stpd_pkg::RD_FW_REV:    read_value = {40'd0, fw_rev_q};
			stpd_pkg::RD_VER_KNOWN: read_value = {63'd0, ver_known_q};
			stpd_pkg::RD_FRAMES:    read_value = {32'd0, stat.frame_count};
			stpd_pkg::RD_ONLINE:    read_value = {63'd0, stat.online};
			default:                read_value = '0;
		endcase
	end

endmodule

// File: design/servo_telemetry_poll_decoder.sv
// top level of the servo telemetry poll decoder: input stage, timers, result sequencer, apb
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------
//  in      | to block  | in_valid / in_stall | in_item   (frame, tick or read)
//  out     | from block| out_valid/out_stall | out_item  (send request or read)
//  apb     | to block  | psel/penable/pready | paddr, pwdata, prdata (4 registers)
//
// a request enters the input register at an edge where that register is empty or commits
// it is decoded and committed when it advances; its 0 to 3 results load the result register
// and are taken from there one per cycle while out_stall is low (up to 3 per tick)
// requests with no results pass a waiting result; one with results holds in the input
// register and stalls the input until the last pending result is taken
// reset clears all telemetry, timers and the pending results; config goes to defaults
module servo_telemetry_poll_decoder (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	output logic                in_stall,
	input  stpd_pkg::in_item_t  in_item,

	output logic                out_valid,
	input  logic                out_stall,
	output stpd_pkg::out_item_t out_item,

	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	localparam int RTB = stpd_pkg::REPLY_TIMER_BITS;
	localparam int CW  = stpd_pkg::RT_CMP_W;
	localparam int SW  = stpd_pkg::SLOT_W;

	// configuration registers
	logic [10:0] servo_id_q;
	logic [7:0]  poll_step_q;
	logic [15:0] slow_poll_q;
	logic [15:0] timeout_q;
	logic        cfg_wr;
	logic [1:0]  cfg_idx;

	assign pready  = 1'b1;
	assign cfg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			servo_id_q  <= stpd_pkg::SERVO_ID_RST;
			poll_step_q <= stpd_pkg::POLL_STEP_RST;
			slow_poll_q <= stpd_pkg::SLOW_POLL_RST;
			timeout_q   <= stpd_pkg::TIMEOUT_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				stpd_pkg::REG_SERVO_ID:  servo_id_q  <= pwdata[10:0];
				stpd_pkg::REG_POLL_STEP: poll_step_q <= pwdata[7:0];
				stpd_pkg::REG_SLOW_POLL: slow_poll_q <= pwdata[15:0];
				stpd_pkg::REG_TIMEOUT:   timeout_q   <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			stpd_pkg::REG_SERVO_ID:  prdata = {21'd0, servo_id_q};
			stpd_pkg::REG_POLL_STEP: prdata = {24'd0, poll_step_q};
			stpd_pkg::REG_SLOW_POLL: prdata = {16'd0, slow_poll_q};
			stpd_pkg::REG_TIMEOUT:   prdata = {16'd0, timeout_q};
			default:                 prdata = '0;
		endcase
	end

	// input register
	logic               valid_s1;
	stpd_pkg::in_item_t item_s1;
	logic               in_accept;
	logic               adv;

	assign in_accept = in_valid && !in_stall;
	assign in_stall  = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= in_item;
		end
	end

	// link and poll timers
	logic [31:0]    frame_count_q;
	logic [RTB-1:0] ms_since_q;
	logic           have_reply_q;
	logic           online_q;
	logic [7:0]     fast_timer_q;
	logic [15:0]    slow_timer_q;
	logic [SW-1:0]  slot_q;

	logic           is_frame, is_tick, is_read;
	logic           frame_hit;
	logic [RTB-1:0] ms_inc;
	logic [7:0]     fast_inc;
	logic [15:0]    slow_inc;
	logic           online_new;
	logic           slow_fire, fast_fire;
	logic [SW-1:0]  slot_cur, slot_nxt;
	logic           has_results;
	logic           free;
	logic           out_accept;

	assign is_frame  = (item_s1.mode == stpd_pkg::MODE_FRAME);
	assign is_tick   = (item_s1.mode == stpd_pkg::MODE_TICK);
	assign is_read   = (item_s1.mode == stpd_pkg::MODE_READ);
	assign frame_hit = is_frame && (item_s1.frame_id == servo_id_q);

	// all timers saturate
	assign ms_inc     = (&ms_since_q)   ? ms_since_q   : ms_since_q + 1'b1;
	assign fast_inc   = (&fast_timer_q) ? fast_timer_q : fast_timer_q + 8'd1;
	assign slow_inc   = (&slow_timer_q) ? slow_timer_q : slow_timer_q + 16'd1;
	assign online_new = have_reply_q && (CW'(ms_inc) < CW'(timeout_q));
	assign slow_fire  = (slow_inc >= slow_poll_q);
	assign fast_fire  = (fast_inc >= poll_step_q);

	assign slot_cur = (slot_q < SW'(stpd_pkg::POLL_SLOTS)) ? slot_q : '0;
	assign slot_nxt = (slot_cur == SW'(stpd_pkg::POLL_SLOTS - 1)) ? '0 : slot_cur + 1'b1;

	assign has_results = is_read || (is_tick && (slow_fire || fast_fire));
	assign out_accept  = out_valid && !out_stall;
	// result register empty now or emptied by this cycle's last result
	assign free        = !out_valid || (out_accept && out_item.last);
	// items with no results commit regardless of what still waits at the output
	assign adv         = valid_s1 && (!has_results || free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
			ms_since_q    <= '0;
			have_reply_q  <= 1'b0;
			online_q      <= 1'b0;
			fast_timer_q  <= '0;
			slow_timer_q  <= '0;
			slot_q        <= '0;
		end else if (adv) begin
			if (frame_hit) begin
				frame_count_q <= frame_count_q + 32'd1;
				ms_since_q    <= '0;
				have_reply_q  <= 1'b1;
			end
			if (is_tick) begin
				ms_since_q   <= ms_inc;
				online_q     <= online_new;
				fast_timer_q <= fast_fire ? 8'd0 : fast_inc;
				slow_timer_q <= slow_fire ? 16'd0 : slow_inc;
				if (fast_fire) slot_q <= slot_nxt;
			end
		end
	end

	// telemetry registers and read select
	stpd_pkg::frame_upd_t upd;
	stpd_pkg::link_stat_t stat;
	logic [63:0]          read_value;

	assign upd.hit          = adv && frame_hit;
	assign upd.len          = item_s1.frame_len;
	assign upd.data         = item_s1.frame_data;
	assign stat.frame_count = frame_count_q;
	assign stat.online      = online_q;

	stpd_telem_regs u_telem (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (upd),
		.stat       (stat),
		.read_index (item_s1.read_index),
		.read_value (read_value)
	);

	// result register: pending flags give the order read, version, drive mode, fast poll
	logic        pend_read_q, pend_ver_q, pend_mode_q, pend_fast_q;
	logic [7:0]  fast_cmd_q;
	logic [63:0] read_value_q;
	logic        online_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_read_q <= 1'b0;
			pend_ver_q  <= 1'b0;
			pend_mode_q <= 1'b0;
			pend_fast_q <= 1'b0;
		end else if (adv && has_results) begin
			pend_read_q <= is_read;
			pend_ver_q  <= is_tick && slow_fire;
			pend_mode_q <= is_tick && slow_fire;
			pend_fast_q <= is_tick && fast_fire;
		end else if (out_accept) begin
			if (pend_read_q) begin
				pend_read_q <= 1'b0;
			end else if (pend_ver_q) begin
				pend_ver_q <= 1'b0;
			end else if (pend_mode_q) begin
				pend_mode_q <= 1'b0;
			end else begin
				pend_fast_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_results) begin
			fast_cmd_q   <= stpd_pkg::poll_cmd(slot_cur);
			read_value_q <= read_value;
			// a read leaves the online flag as it is
			online_out_q <= is_tick ? online_new : online_q;
		end
	end

	assign out_valid = pend_read_q || pend_ver_q || pend_mode_q || pend_fast_q;

	always_comb begin
		out_item              = '0;
		out_item.online       = online_out_q;
		out_item.kind         = stpd_pkg::KIND_SEND;
		if (pend_read_q) begin
			out_item.kind       = stpd_pkg::KIND_READ;
			out_item.read_value = read_value_q;
			out_item.last       = 1'b1;
		end else if (pend_ver_q) begin
			out_item.send_command = stpd_pkg::CMD_VERSION;
			out_item.last         = !(pend_mode_q || pend_fast_q);
		end else if (pend_mode_q) begin
			out_item.send_command = stpd_pkg::CMD_PARAM_RD;
			out_item.send_has_arg = 1'b1;
			out_item.send_arg     = stpd_pkg::ARG_DRV_MODE;
			out_item.last         = !pend_fast_q;
		end else begin
			out_item.send_command = fast_cmd_q;
			out_item.last         = 1'b1;
		end
	end

endmodule
